### hw/rtl/csf_pkg.sv
// Shared types and constants for the keyed content store.
package csf_pkg;

    localparam int DEPTH_DEF   = 64;
    localparam int KEY_W       = 64;
    localparam int CONTENT_W   = 64;
    localparam int CFG_W       = 7;
    localparam int LOC_W       = 6;
    localparam int CNT_OUT_W   = 7;

    localparam logic [CFG_W-1:0] PINNED_RESET = 7'd0;
    localparam logic [CFG_W-1:0] LIMIT_RESET  = 7'd64;

    localparam logic REG_PINNED = 1'b0;
    localparam logic REG_LIMIT  = 1'b1;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [CONTENT_W-1:0] content;
    } entry_t;

endpackage

### hw/rtl/csf_ram.sv
// Single-write, single-read entry memory with registered read data.
module csf_ram
    import csf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/content_store_fifo_pinned.sv
// Keyed content store with FIFO replacement and pinned leading entries.
//
// Requests arrive on in_valid/in_ready with req_type, key and content; one
// result item per request leaves on out_valid/out_ready. in_ready is high only
// while the sequencer is idle; one request is worked on at a time.
// A request scans the stored entries through a single memory read port and a
// single 64-bit key comparator, one entry per cycle, for a lookup or a
// duplicate check. An insert that evicts then moves each entry behind the
// evicted position down by one, one entry per cycle through the same read and
// write ports, and then appends the new entry.
// The result is held in an output register; the next request is accepted
// while it waits, and a finished request holds in its last state only if the
// previous result has still not been taken.
// Reset empties the store (count zero, memory contents left as they are),
// sets pinned_count to 0 and capacity_limit to 64. Configuration writes
// through cfg_wr_en/cfg_index/cfg_data take effect at once; the user must make
// them only while no request is in flight, as the block does not enforce it.
module content_store_fifo_pinned
    import csf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [KEY_W-1:0]     key,
    input  logic [CONTENT_W-1:0] content,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 accepted,
    output logic                 hit,
    output logic                 evicted,
    output logic [LOC_W-1:0]     evicted_location,
    output logic [CONTENT_W-1:0] found_content,
    output logic [CNT_OUT_W-1:0] entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_SHIFT  = 5'b00100,
        ST_APPEND = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]     pinned_reg, limit_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        waddr_reg, waddr_next;
    logic                 pend_reg, pend_next;

    logic                 req_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [CONTENT_W-1:0] content_reg;

    logic                 res_acc_reg, res_acc_next;
    logic                 res_hit_reg, res_hit_next;
    logic                 res_evc_reg, res_evc_next;
    logic [CONTENT_W-1:0] res_found_reg, res_found_next;

    logic                 out_valid_reg;
    logic                 out_acc_reg, out_hit_reg, out_evc_reg;
    logic [LOC_W-1:0]     out_loc_reg;
    logic [CONTENT_W-1:0] out_found_reg;
    logic [CNT_OUT_W-1:0] out_cnt_reg;

    logic                 wr_en, rd_en;
    logic [AW-1:0]        wr_addr, rd_addr;
    entry_t               wr_data, rd_data;

    logic [LW-1:0]        lim, cap_ext, pin_ext, cnt_ext;
    logic [CW-1:0]        idx_m1, pin_p1;
    logic                 match, load_out;

    csf_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        cap_ext = LW'(limit_reg);
        pin_ext = LW'(pinned_reg);
        cnt_ext = LW'(count_reg);
        if (limit_reg == '0)
        begin
            lim = LW'(1);
        end
        else if (cap_ext > LW'(DEPTH))
        begin
            lim = LW'(DEPTH);
        end
        else
        begin
            lim = cap_ext;
        end
    end

    assign idx_m1   = idx_reg - CW'(1);
    assign pin_p1   = CW'(pin_ext + LW'(1));
    assign match    = pend_reg && (rd_data.key == key_reg);
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        waddr_next     = waddr_reg;
        pend_next      = 1'b0;
        res_acc_next   = res_acc_reg;
        res_hit_next   = res_hit_reg;
        res_evc_next   = res_evc_reg;
        res_found_next = res_found_reg;
        wr_en          = 1'b0;
        wr_addr        = waddr_reg;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next     = ST_SCAN;
                    idx_next       = '0;
                    res_acc_next   = 1'b0;
                    res_hit_next   = 1'b0;
                    res_evc_next   = 1'b0;
                    res_found_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    res_hit_next = 1'b1;
                    if (req_reg == REQ_LOOKUP)
                    begin
                        res_found_next = rd_data.content;
                    end
                    state_next = ST_FINISH;
                end
                else if (idx_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else if (req_reg == REQ_LOOKUP || pin_ext >= lim)
                begin
                    state_next = ST_FINISH;
                end
                else if (cnt_ext >= lim)
                begin
                    res_evc_next = 1'b1;
                    idx_next     = pin_p1;
                    state_next   = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    wr_en = 1'b1;
                end
                if (idx_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    idx_next   = idx_reg + CW'(1);
                    waddr_next = idx_m1[AW-1:0];
                    pend_next  = 1'b1;
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                wr_en        = 1'b1;
                wr_addr      = count_reg[AW-1:0];
                wr_data      = '{key: key_reg, content: content_reg};
                count_next   = count_reg + CW'(1);
                res_acc_next = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pinned_reg    <= PINNED_RESET;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_PINNED: pinned_reg <= cfg_data;
                    REG_LIMIT:  limit_reg  <= cfg_data;
                    default:    limit_reg  <= limit_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        waddr_reg     <= waddr_next;
        res_acc_reg   <= res_acc_next;
        res_hit_reg   <= res_hit_next;
        res_evc_reg   <= res_evc_next;
        res_found_reg <= res_found_next;
        if (in_valid && in_ready)
        begin
            req_reg     <= req_type;
            key_reg     <= key;
            content_reg <= content;
        end
        if (load_out)
        begin
            out_acc_reg   <= res_acc_reg;
            out_hit_reg   <= res_hit_reg;
            out_evc_reg   <= res_evc_reg;
            out_loc_reg   <= res_evc_reg ? pinned_reg[LOC_W-1:0] : '0;
            out_found_reg <= res_found_reg;
            out_cnt_reg   <= cnt_ext[CNT_OUT_W-1:0];
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = out_acc_reg;
    assign hit              = out_hit_reg;
    assign evicted          = out_evc_reg;
    assign evicted_location = out_loc_reg;
    assign found_content    = out_found_reg;
    assign entry_count      = out_cnt_reg;

endmodule

### hw/rtl/csf_checker.sv
// Port-level checks for the keyed content store, bound to the top level.
module csf_checker
    import csf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 accepted,
    input  logic                 hit,
    input  logic                 evicted,
    input  logic [LOC_W-1:0]     evicted_location,
    input  logic [CONTENT_W-1:0] found_content,
    input  logic [CNT_OUT_W-1:0] entry_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found_content)
            && $stable(entry_count) && $stable(hit))
        else $error("result changed while stalled");

    a_insert_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> !hit && found_content == '0)
        else $error("stored insert reports hit or content");

    a_evict_stored: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> accepted && entry_count != '0)
        else $error("eviction without a stored insert");

    a_loc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted |-> evicted_location == '0)
        else $error("location set without eviction");

endmodule

bind content_store_fifo_pinned csf_checker u_csf_checker (.*);

### tb/content_store_fifo_pinned_tb.sv
// Self-checking testbench for the keyed content store with FIFO replacement and pinned entries.
module content_store_fifo_pinned_tb
    import csf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 2 * DEPTH_DEF + 20;

    typedef struct packed {
        logic                 accepted;
        logic                 hit;
        logic                 evicted;
        logic [LOC_W-1:0]     location;
        logic [CONTENT_W-1:0] found;
        logic [CNT_OUT_W-1:0] count;
    } store_result_t;

    typedef enum int {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    class content_store_tracker;
        logic [KEY_W-1:0]     shadow_keys[DEPTH_DEF];
        logic [CONTENT_W-1:0] shadow_contents[DEPTH_DEF];
        int                   shadow_count;
        logic [CFG_W-1:0]     pinned_reg;
        logic [CFG_W-1:0]     limit_reg;
        store_result_t        awaited_results[$];
        int                   errors;
        int                   n_requests;
        int                   n_hits;
        int                   n_stored;
        int                   n_evictions;
        int                   n_refused;

        function new();
            shadow_count = 0;
            pinned_reg   = PINNED_RESET;
            limit_reg    = LIMIT_RESET;
            errors       = 0;
            n_requests   = 0;
            n_hits       = 0;
            n_stored     = 0;
            n_evictions  = 0;
            n_refused    = 0;
        endfunction

        function void write_reg(logic index, logic [CFG_W-1:0] value);
            if (index == REG_PINNED)
                pinned_reg = value;
            else
                limit_reg = value;
        endfunction

        function int find_entry(logic [KEY_W-1:0] k);
            for (int i = 0; i < shadow_count; i++)
                if (shadow_keys[i] == k)
                    return i;
            return -1;
        endfunction

        function void note_request(logic r, logic [KEY_W-1:0] k, logic [CONTENT_W-1:0] c);
            store_result_t res;
            int            pos;
            int            lim;
            int            p;
            res = '0;
            pos = find_entry(k);
            n_requests++;
            if (r == REQ_LOOKUP)
            begin
                if (pos >= 0)
                begin
                    res.hit   = 1'b1;
                    res.found = shadow_contents[pos];
                end
            end
            else if (pos >= 0)
            begin
                res.hit = 1'b1;
            end
            else
            begin
                lim = (limit_reg == 0) ? 1 : ((limit_reg > DEPTH_DEF) ? DEPTH_DEF : limit_reg);
                if (pinned_reg < lim)
                begin
                    if (shadow_count >= lim)
                    begin
                        p = pinned_reg;
                        for (int i = p; i < shadow_count - 1; i++)
                        begin
                            shadow_keys[i]     = shadow_keys[i + 1];
                            shadow_contents[i] = shadow_contents[i + 1];
                        end
                        shadow_count--;
                        res.evicted  = 1'b1;
                        res.location = p[LOC_W-1:0];
                        n_evictions++;
                    end
                    if (shadow_count < DEPTH_DEF)
                    begin
                        shadow_keys[shadow_count]     = k;
                        shadow_contents[shadow_count] = c;
                        shadow_count++;
                        res.accepted = 1'b1;
                        n_stored++;
                    end
                end
                if (!res.accepted)
                    n_refused++;
            end
            if (res.hit)
                n_hits++;
            res.count = shadow_count[CNT_OUT_W-1:0];
            awaited_results = {awaited_results, res};
        endfunction

        function void flag(string what, logic [63:0] exp_v, logic [63:0] act_v);
            errors++;
            if (errors <= 10)
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, exp_v, act_v);
        endfunction

        function void check_result(store_result_t act);
            store_result_t exp_r;
            if (awaited_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result item with none awaited: %p", $time, act);
                return;
            end
            exp_r = awaited_results.pop_front();
            if (act.accepted !== exp_r.accepted) flag("accepted", exp_r.accepted, act.accepted);
            if (act.hit !== exp_r.hit) flag("hit", exp_r.hit, act.hit);
            if (act.evicted !== exp_r.evicted) flag("evicted", exp_r.evicted, act.evicted);
            if (act.location !== exp_r.location)
                flag("evicted_location", exp_r.location, act.location);
            if (act.found !== exp_r.found) flag("found_content", exp_r.found, act.found);
            if (act.count !== exp_r.count) flag("entry_count", exp_r.count, act.count);
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_index = REG_PINNED;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 req_type = REQ_INSERT;
    logic [KEY_W-1:0]     key = '0;
    logic [CONTENT_W-1:0] content = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 accepted;
    logic                 hit;
    logic                 evicted;
    logic [LOC_W-1:0]     evicted_location;
    logic [CONTENT_W-1:0] found_content;
    logic [CNT_OUT_W-1:0] entry_count;

    content_store_tracker tracker = new();
    logic [KEY_W-1:0]     key_pool[$];
    int                   hold_left = 0;
    int                   mode_left = 0;
    rx_mode_t             rx_mode = RX_FREE;

    content_store_fifo_pinned DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .key              (key),
        .content          (content),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .accepted         (accepted),
        .hit              (hit),
        .evicted          (evicted),
        .evicted_location (evicted_location),
        .found_content    (found_content),
        .entry_count      (entry_count)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result({accepted, hit, evicted, evicted_location,
                                  found_content, entry_count});
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (rx_mode)
                RX_FREE:     out_ready <= 1'b1;
                RX_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: out_ready <= ((mode_left % 5) < 2);
                default:     out_ready <= 1'b1;
            endcase
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(logic r, logic [KEY_W-1:0] k, logic [CONTENT_W-1:0] c);
        in_valid <= 1'b1;
        req_type <= r;
        key      <= k;
        content  <= c;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_request(r, k, c);
    endtask

    task automatic pause(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(int pinned, int limit);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PINNED;
        cfg_data  <= pinned[CFG_W-1:0];
        @(posedge clk);
        tracker.write_reg(REG_PINNED, pinned[CFG_W-1:0]);
        cfg_index <= REG_LIMIT;
        cfg_data  <= limit[CFG_W-1:0];
        @(posedge clk);
        tracker.write_reg(REG_LIMIT, limit[CFG_W-1:0]);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(int pinned, int limit, int items, bit long_hold);
        int               lim;
        int               burst;
        int               pick;
        logic             r;
        logic [KEY_W-1:0] k;
        logic [63:0]      c;
        set_config(pinned, limit);
        lim = limit[CFG_W-1:0];
        lim = (lim == 0) ? 1 : ((lim > DEPTH_DEF) ? DEPTH_DEF : lim);
        while (key_pool.size() > 16)
            void'(key_pool.pop_front());
        repeat (lim + lim / 2 + 2)
            key_pool = {key_pool, rand64()};
        if (long_hold)
            hold_left = 400;
        while (items > 0)
        begin
            burst = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
            while (burst > 0 && items > 0)
            begin
                pick = $urandom_range(0, 99);
                r = ($urandom_range(0, 99) < 55) ? REQ_INSERT : REQ_LOOKUP;
                k = (pick < 8) ? rand64() : key_pool[$urandom_range(0, key_pool.size() - 1)];
                c = (pick >= 95) ? '1 : ((pick >= 90) ? '0 : rand64());
                send_item(r, k, c);
                burst--;
                items--;
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 8));
        end
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("content_store_fifo_pinned_tb failed");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(REQ_INSERT, 64'h0, '1);
        send_item(REQ_INSERT, '1, 64'h0);
        set_config(0, 3);
        send_item(REQ_INSERT, 64'h0, 64'h1234);
        send_item(REQ_LOOKUP, '1, rand64());
        send_item(REQ_LOOKUP, 64'h8000_0000_0000_0000, '1);
        send_item(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_item(REQ_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(REQ_LOOKUP, 64'h0, '0);
        set_config(2, 3);
        send_item(REQ_INSERT, 64'h1, 64'hDEAD_BEEF_0000_0001);
        send_item(REQ_LOOKUP, '1, '0);
        set_config(3, 3);
        send_item(REQ_INSERT, 64'h8000_0000_0000_0000, 64'h77);
        send_item(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h99);
        set_config(0, 0);
        send_item(REQ_INSERT, 64'h0F0F_0F0F_F0F0_F0F0, 64'h0123_4567_89AB_CDEF);
        send_item(REQ_LOOKUP, 64'h0F0F_0F0F_F0F0_F0F0, '0);
        set_config(64, 127);
        send_item(REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFE, 64'h42);
        send_item(REQ_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        set_config(127, 64);
        send_item(REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFE, 64'h42);
        set_config(0, 64);
        send_item(REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFE, 64'h42);
        send_item(REQ_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFE, '1);

        run_phase(0, 64, 220, 1'b1);
        run_phase(3, 64, 120, 1'b0);
        run_phase(2, 8, 100, 1'b0);
        run_phase(0, 1, 60, 1'b0);
        run_phase(1, 2, 60, 1'b0);
        run_phase(10, 16, 100, 1'b0);
        run_phase(63, 64, 100, 1'b0);
        run_phase(0, 127, 100, 1'b0);
        run_phase(70, 100, 40, 1'b0);
        run_phase(5, 0, 40, 1'b0);
        run_phase(0, 0, 60, 1'b0);
        run_phase(4, 20, 100, 1'b0);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests %0d: %0d hits, %0d stored, %0d evictions, %0d refused inserts",
                 tracker.n_requests, tracker.n_hits, tracker.n_stored,
                 tracker.n_evictions, tracker.n_refused);
        $display("pinned counts 0..127 and limits 0..127 exercised, %0d errors",
                 tracker.errors);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("content_store_fifo_pinned_tb passed");
        else
            $display("content_store_fifo_pinned_tb failed");
        $finish;
    end

endmodule
